### rtl/srfc_pkg.sv
package srfc_pkg;

    // Frame layout.
    localparam int FRAME_LENGTH = 9;
    localparam int POS_W        = 4;
    localparam int STORE_DEPTH  = FRAME_LENGTH - 1;
    localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);
    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

    // Input operation codes.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd3;

    // One result: status and frame bytes 1 to 7 (element 0 holds byte 1).
    typedef struct packed {
        logic [1:0]      status;
        logic [6:0][7:0] frame;
    } result_t;

endpackage

### rtl/srfc_frame_assembler.sv
module srfc_frame_assembler (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             operation,
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       expected_command,
    output logic             result_valid,
    output srfc_pkg::result_t result
);
    import srfc_pkg::*;

    logic [POS_W-1:0] byte_position_reg;
    logic [POS_W-1:0] byte_position_next;
    logic [7:0]       running_sum_reg;
    logic [7:0]       running_sum_next;
    logic [7:0]       frame_bytes_reg [STORE_DEPTH];
    logic             frame_done;
    logic             store_byte;
    logic [7:0]       check_byte;

    // The ninth byte, or any position past the store, closes the frame.
    assign frame_done = (byte_position_reg >= LAST_POS);
    assign store_byte = accept && (operation == OP_BYTE) && !frame_done;
    assign check_byte = 8'(8'd0 - running_sum_reg);

    // Position and checksum update for each accepted transaction.
    always_comb
    begin
        byte_position_next = byte_position_reg;
        running_sum_next   = running_sum_reg;
        if (accept)
        begin
            if (operation == OP_TIMEOUT || frame_done)
            begin
                byte_position_next = '0;
                running_sum_next   = '0;
            end
            else
            begin
                byte_position_next = byte_position_reg + POS_W'(1);
                if (byte_position_reg != '0)
                begin
                    running_sum_next = running_sum_reg + rx_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            running_sum_reg   <= '0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            running_sum_reg   <= running_sum_next;
        end
    end

    // Frame byte store; contents are meaningful only once written.
    always_ff @(posedge clk)
    begin
        if (store_byte)
        begin
            frame_bytes_reg[byte_position_reg[STORE_IDX_W-1:0]] <= rx_byte;
        end
    end

    // Result for a timeout or a completed frame.
    always_comb
    begin
        result_valid = accept && (operation == OP_TIMEOUT || frame_done);
        result       = '0;
        if (operation == OP_TIMEOUT)
        begin
            result.status = STATUS_TIMEOUT;
        end
        else
        begin
            if (frame_bytes_reg[0] != HEADER_BYTE || frame_bytes_reg[1] != expected_command)
            begin
                result.status = STATUS_MISMATCH;
            end
            else if (rx_byte != check_byte)
            begin
                result.status = STATUS_CHECKSUM;
            end
            else
            begin
                result.status = STATUS_OK;
            end
            for (int k = 0; k < STORE_DEPTH - 1; k++)
            begin
                result.frame[k] = frame_bytes_reg[k + 1];
            end
        end
    end

endmodule

### rtl/srfc_result_reg.sv
module srfc_result_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  srfc_pkg::result_t load_data,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              take_ready,
    output srfc_pkg::result_t out_data
);
    import srfc_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;

    // A new transaction may enter while the held result is being taken.
    assign take_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= load_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/sensor_reply_frame_checker_unit.sv
// Sensor reply frame checker: takes one serial byte or timeout per transaction and, on the
// ninth byte of a frame or on a timeout, returns one result with a status (ok, checksum
// error, header or command mismatch, timeout), the echoed command and payload bytes 2 to 7.
// A transaction is taken every cycle that in_ready is high; a result appears at the output
// register in the cycle after the transaction that causes it, and in_ready drops only while
// a result is held in that register and out_ready is low.
module sensor_reply_frame_checker_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] rx_byte,
    input  logic [7:0] expected_command,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] echoed_command,
    output logic [7:0] payload_2,
    output logic [7:0] payload_3,
    output logic [7:0] payload_4,
    output logic [7:0] payload_5,
    output logic [7:0] payload_6,
    output logic [7:0] payload_7
);
    import srfc_pkg::*;

    logic    accept;
    logic    result_valid;
    result_t result;
    result_t held;

    assign accept = in_valid && in_ready;

    // Frame collection and checking.
    srfc_frame_assembler u_assembler (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .operation        (operation),
        .rx_byte          (rx_byte),
        .expected_command (expected_command),
        .result_valid     (result_valid),
        .result           (result)
    );

    // Output register.
    srfc_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (result_valid),
        .load_data  (result),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .take_ready (in_ready),
        .out_data   (held)
    );

    assign status         = held.status;
    assign echoed_command = held.frame[0];
    assign payload_2      = held.frame[1];
    assign payload_3      = held.frame[2];
    assign payload_4      = held.frame[3];
    assign payload_5      = held.frame[4];
    assign payload_6      = held.frame[5];
    assign payload_7      = held.frame[6];

endmodule

### verif/sensor_reply_frame_checker_unit_test.sv
`timescale 1ns / 100ps

module sensor_reply_frame_checker_unit_test;
    import srfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TRAILING_CYCLES = 4;

    // Tracks frame assembly and holds the replies still owed by the block.
    class reply_tracker;
        logic [POS_W-1:0] byte_pos;
        logic [7:0]       held_bytes [STORE_DEPTH];
        logic [7:0]       byte_sum;
        result_t          expected_replies [$];
        int               error_count;
        int               input_count;
        int               status_seen [4];

        function new();
            byte_pos = '0;
            byte_sum = '0;
            error_count = 0;
            input_count = 0;
            foreach (held_bytes[k]) held_bytes[k] = '0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        // Update the frame state for one accepted input transaction.
        function void note_transaction(logic op, logic [7:0] rx, logic [7:0] cmd);
            result_t    reply;
            logic [7:0] check_byte;
            input_count++;
            if (op == OP_TIMEOUT) begin
                reply.status = STATUS_TIMEOUT;
                reply.frame = '0;
                expected_replies.push_back(reply);
                byte_pos = '0;
                byte_sum = '0;
            end
            else if (byte_pos < LAST_POS) begin
                held_bytes[byte_pos[STORE_IDX_W-1:0]] = rx;
                if (byte_pos != '0)
                    byte_sum = byte_sum + rx;
                byte_pos = byte_pos + 1'b1;
            end
            else begin
                check_byte = 8'd0 - byte_sum;
                reply.status = STATUS_OK;
                if (rx != check_byte)
                    reply.status = STATUS_CHECKSUM;
                // A header or command mismatch wins over a checksum error.
                if (held_bytes[0] != HEADER_BYTE || held_bytes[1] != cmd)
                    reply.status = STATUS_MISMATCH;
                for (int k = 0; k < 7; k++)
                    reply.frame[k] = held_bytes[k + 1];
                expected_replies.push_back(reply);
                byte_pos = '0;
                byte_sum = '0;
            end
        endfunction

        task report(string what, int got, int want);
            error_count++;
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        endtask

        // Compare one accepted reply with the oldest expected one.
        task check_reply(logic [1:0] st, logic [7:0] got_bytes [7]);
            result_t want;
            string   field_name;
            if (expected_replies.size() == 0) begin
                report("reply with none expected, status", st, 0);
            end
            else begin
                want = expected_replies.pop_front();
                status_seen[want.status]++;
                if (st !== want.status)
                    report("status", st, want.status);
                for (int k = 0; k < 7; k++) begin
                    field_name = (k == 0) ? "echoed_command" : $sformatf("payload_%0d", k + 1);
                    if (got_bytes[k] !== want.frame[k])
                        report(field_name, got_bytes[k], want.frame[k]);
                end
            end
        endtask

        function int pending_count();
            return expected_replies.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       operation;
    logic [7:0] rx_byte;
    logic [7:0] expected_command;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [7:0] echoed_command;
    logic [7:0] payload_2;
    logic [7:0] payload_3;
    logic [7:0] payload_4;
    logic [7:0] payload_5;
    logic [7:0] payload_6;
    logic [7:0] payload_7;

    reply_tracker tracker;
    bit           idle_on;
    int           items_sent;
    int           sent_pos;
    int           quiet_cycles;
    logic [7:0]   reply_bytes [7];

    sensor_reply_frame_checker_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .rx_byte          (rx_byte),
        .expected_command (expected_command),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .echoed_command   (echoed_command),
        .payload_2        (payload_2),
        .payload_3        (payload_3),
        .payload_4        (payload_4),
        .payload_5        (payload_5),
        .payload_6        (payload_6),
        .payload_7        (payload_7)
    );

    // Clock generation, 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor: check replies, record inputs and watch for a hung handshake.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                reply_bytes = '{echoed_command, payload_2, payload_3, payload_4,
                                payload_5, payload_6, payload_7};
                tracker.check_reply(status, reply_bytes);
            end
            if (in_valid && in_ready)
                tracker.note_transaction(operation, rx_byte, expected_command);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end
            else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Watchdog expired after %0d cycles without a transaction",
                             quiet_cycles);
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    // Receiver: random stall bursts while idling is enabled.
    initial
    begin
        out_ready = 1'b1;
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_ready = 1'b1;
            end
        end
    end

    // Drive one input transaction and wait until it is accepted.
    task send_item(input logic op, input logic [7:0] rx, input logic [7:0] cmd);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid = 1'b1;
        operation = op;
        rx_byte = rx;
        expected_command = cmd;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        if (op == OP_TIMEOUT || sent_pos == FRAME_LENGTH - 1)
            sent_pos = 0;
        else
            sent_pos++;
    endtask

    // Stop sending and wait for every outstanding reply.
    task drain_replies();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pending_count() != 0) @(posedge clk);
    endtask

    // Mostly well-formed frames with random content, some corrupted or cut short.
    task send_random_frame();
        logic [7:0] frame [FRAME_LENGTH];
        logic [7:0] acc;
        logic [7:0] cmd;
        int         cut;
        frame[0] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : HEADER_BYTE;
        acc = '0;
        for (int k = 1; k < FRAME_LENGTH - 1; k++) begin
            frame[k] = 8'($urandom);
            acc = acc + frame[k];
        end
        frame[FRAME_LENGTH - 1] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'd0 - acc;
        cmd = ($urandom_range(0, 7) == 0) ? 8'($urandom) : frame[1];
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, FRAME_LENGTH - 1) : FRAME_LENGTH;
        // Usually realign first if noise left a partial frame behind.
        if (sent_pos != 0 && $urandom_range(0, 3) != 0)
            send_item(OP_TIMEOUT, 8'($urandom), 8'($urandom));
        for (int k = 0; k < cut; k++)
            send_item(OP_BYTE, frame[k], (k == FRAME_LENGTH - 1) ? cmd : 8'($urandom));
        if (cut < FRAME_LENGTH)
            send_item(OP_TIMEOUT, 8'($urandom), 8'($urandom));
    endtask

    // Unstructured bytes with the odd timeout.
    task send_noise();
        int count;
        count = $urandom_range(1, 12);
        repeat (count) begin
            send_item(($urandom_range(0, 9) == 0) ? OP_TIMEOUT : OP_BYTE,
                      8'($urandom), 8'($urandom));
        end
    endtask

    task run_random(int target);
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 85)
                send_random_frame();
            else
                send_noise();
        end
    endtask

    // Main sequence.
    initial
    begin
        tracker = new();
        idle_on = 1'b1;
        items_sent = 0;
        sent_pos = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_BYTE;
        rx_byte = '0;
        expected_command = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Good frame with all-zero content.
        send_item(OP_BYTE, HEADER_BYTE, 8'hFF);
        repeat (FRAME_LENGTH - 1) send_item(OP_BYTE, 8'h00, 8'h00);
        // Bad header together with a bad checksum; the mismatch must win.
        send_item(OP_BYTE, 8'h00, 8'h00);
        repeat (FRAME_LENGTH - 2) send_item(OP_BYTE, 8'hFF, 8'h00);
        send_item(OP_BYTE, 8'hFF, 8'hFF);
        // Timeout with nothing held, then a timeout dropping a partial frame.
        send_item(OP_TIMEOUT, 8'hFF, 8'hFF);
        send_item(OP_BYTE, HEADER_BYTE, 8'h86);
        send_item(OP_BYTE, 8'h12, 8'h86);
        send_item(OP_TIMEOUT, 8'h00, 8'h00);
        drain_replies();

        run_random(800);
        // Hold the sender off until every reply is back.
        drain_replies();
        run_random(1450);
        drain_replies();
        // Final stretch at full rate on both sides.
        idle_on = 1'b0;
        run_random(1700);

        drain_replies();
        repeat (TRAILING_CYCLES) @(posedge clk);
        if (tracker.pending_count() != 0)
            tracker.report("replies never produced, count", tracker.pending_count(), 0);

        $display("Sent %0d input transactions; replies checked: %0d ok, %0d checksum error,",
                 tracker.input_count, tracker.status_seen[STATUS_OK],
                 tracker.status_seen[STATUS_CHECKSUM]);
        $display("%0d header or command mismatch, %0d timeout; %0d mismatches found",
                 tracker.status_seen[STATUS_MISMATCH], tracker.status_seen[STATUS_TIMEOUT],
                 tracker.error_count);
        if (tracker.error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sensor_reply_frame_checker_unit.f
rtl/srfc_pkg.sv
rtl/srfc_frame_assembler.sv
rtl/srfc_result_reg.sv
rtl/sensor_reply_frame_checker_unit.sv
verif/sensor_reply_frame_checker_unit_test.sv
